// ===== hw/rtl/sha_pkg.sv =====
// SHA-256 engine shared definitions: round constants, initial hash, state and command types.
// Used by sha_ctrl, sha_dp and sha256_hash. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    WSEL_DATA,
    WSEL_PAD80,
    WSEL_ZERO,
    WSEL_LEN_HI,
    WSEL_LEN_LO
  } wsel_t;

  typedef struct packed {
    logic  push;        // write a word into the window
    wsel_t wsel;
    logic  len_add;     // add accepted bytes to bit length
    logic  comp_start;  // load working vars from hash
    logic  round_en;    // run one round
    logic  final_add;   // add working vars into hash
    logic  out_load;    // load output register with next digest word
    logic  finish;      // restore initial hash, clear length
  } cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic       round_last;
    logic [2:0] out_idx;
  } stat_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha_dp.sv =====
// SHA-256 datapath: schedule window, working variables, hash, bit length, output register.
// Depends on sha_pkg; driven by sha_ctrl commands.
module sha_dp (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::cmd_t    cmd,
  output sha_pkg::stat_t   stat,
  input  logic [31:0]      data_word,
  input  logic [2:0]       byte_count,
  input  logic             last,
  output logic [31:0]      out_word
);

  logic [31:0] win [16];
  logic [31:0] wv [8];
  logic [31:0] hash [8];
  logic [63:0] bit_len;
  logic [3:0]  fill;
  logic [5:0]  round;
  logic [2:0]  out_idx;

  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [31:0] in_word;
  logic [31:0] push_word;
  logic [3:0]  rt;
  logic [31:0] wa, wb, s0, s1, w_new, w;
  logic [31:0] t1, t2, ch, maj, e1, e0;

  always_comb begin
    cnt = (!last || byte_count > 3'd4) ? 3'd4 : byte_count;
    case (cnt)
      3'd1:    mask = 32'hff00_0000;
      3'd2:    mask = 32'hffff_0000;
      3'd3:    mask = 32'hffff_ff00;
      default: mask = 32'hffff_ffff;
    endcase
    // short last word carries its own 0x80 marker
    case (cnt)
      3'd1:    in_word = (data_word & mask) | 32'h0080_0000;
      3'd2:    in_word = (data_word & mask) | 32'h0000_8000;
      3'd3:    in_word = (data_word & mask) | 32'h0000_0080;
      default: in_word = data_word;
    endcase
    case (cmd.wsel)
      sha_pkg::WSEL_DATA:   push_word = in_word;
      sha_pkg::WSEL_PAD80:  push_word = sha_pkg::PAD_WORD;
      sha_pkg::WSEL_LEN_HI: push_word = bit_len[63:32];
      sha_pkg::WSEL_LEN_LO: push_word = bit_len[31:0];
      default:              push_word = '0;
    endcase

    rt = round[3:0];
    wa = win[4'(rt - 4'd2)];
    wb = win[4'(rt - 4'd15)];
    s1 = sha_pkg::rotr(wa, 17) ^ sha_pkg::rotr(wa, 19) ^ (wa >> 10);
    s0 = sha_pkg::rotr(wb, 7) ^ sha_pkg::rotr(wb, 18) ^ (wb >> 3);
    w_new = s1 + win[4'(rt - 4'd7)] + s0 + win[rt];
    w = (round >= 6'd16) ? w_new : win[rt];
    e1 = sha_pkg::rotr(wv[4], 6) ^ sha_pkg::rotr(wv[4], 11) ^ sha_pkg::rotr(wv[4], 25);
    ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    e0 = sha_pkg::rotr(wv[0], 2) ^ sha_pkg::rotr(wv[0], 13) ^ sha_pkg::rotr(wv[0], 22);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1 = wv[7] + e1 + ch + sha_pkg::ROUND_K[round] + w;
    t2 = e0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      round   <= '0;
      out_idx <= '0;
      bit_len <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha_pkg::INIT_HASH[i];
        wv[i]   <= '0;
      end
    end else begin
      if (cmd.push) begin
        win[fill] <= push_word;
        fill      <= fill + 4'd1;
      end
      if (cmd.len_add) bit_len <= bit_len + {58'd0, cnt, 3'd0};
      if (cmd.comp_start) begin
        for (int i = 0; i < 8; i++) wv[i] <= hash[i];
        round <= '0;
      end
      if (cmd.round_en) begin
        if (round >= 6'd16) win[rt] <= w_new;
        for (int i = 1; i < 8; i++) wv[i] <= wv[i-1];
        wv[4] <= wv[3] + t1;
        wv[0] <= t1 + t2;
        round <= round + 6'd1;
      end
      if (cmd.final_add) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
      end
      if (cmd.out_load) begin
        out_word <= hash[out_idx];
        out_idx  <= out_idx + 3'd1;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INIT_HASH[i];
        bit_len <= '0;
        fill    <= '0;
        out_idx <= '0;
      end
    end
  end

  assign stat.fill       = fill;
  assign stat.round_last = (round == 6'd63);
  assign stat.out_idx    = out_idx;

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: sequences word intake, padding, rounds and digest output.
// Depends on sha_pkg; commands sha_dp.
module sha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      byte_count,
  input  logic            last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  output sha_pkg::cmd_t   cmd,
  input  sha_pkg::stat_t  stat
);

  sha_pkg::state_t state, state_next, ret, ret_next;
  logic pend80, pend80_next;     // full last word still owes the 0x80 word
  logic ov, ov_next, ol, ol_next;

  logic win_full;
  assign win_full = (stat.fill == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sha_pkg::ST_IDLE;
      ret    <= sha_pkg::ST_IDLE;
      pend80 <= 1'b0;
      ov     <= 1'b0;
      ol     <= 1'b0;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      pend80 <= pend80_next;
      ov     <= ov_next;
      ol     <= ol_next;
    end
  end

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    pend80_next = pend80;
    ov_next     = ov;
    ol_next     = ol;
    cmd         = '0;
    cmd.wsel    = sha_pkg::WSEL_DATA;
    in_ready    = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.len_add = 1'b1;
          if (last && byte_count == 3'd0) begin
            cmd.push = 1'b1;
            cmd.wsel = sha_pkg::WSEL_PAD80;
          end else begin
            cmd.push = 1'b1;
          end
          pend80_next = last && (byte_count >= 3'd4);
          if (win_full) begin
            state_next = sha_pkg::ST_COMP;
            cmd.comp_start = 1'b1;
            ret_next = last ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
          end else if (last && byte_count < 3'd4 && stat.fill == 4'd13) begin
            // marker already in word 13: length goes straight in
            state_next = sha_pkg::ST_LEN_HI;
          end else if (last) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        cmd.wsel = pend80 ? sha_pkg::WSEL_PAD80 : sha_pkg::WSEL_ZERO;
        pend80_next = 1'b0;
        if (win_full) begin
          state_next = sha_pkg::ST_COMP;
          cmd.comp_start = 1'b1;
          ret_next = sha_pkg::ST_PAD;
        end else if (stat.fill == 4'd13) begin
          state_next = sha_pkg::ST_LEN_HI;
        end
      end
      sha_pkg::ST_LEN_HI: begin
        cmd.push = 1'b1;
        cmd.wsel = sha_pkg::WSEL_LEN_HI;
        state_next = sha_pkg::ST_LEN_LO;
      end
      sha_pkg::ST_LEN_LO: begin
        cmd.push = 1'b1;
        cmd.wsel = sha_pkg::WSEL_LEN_LO;
        cmd.comp_start = 1'b1;
        ret_next = sha_pkg::ST_OUT;
        state_next = sha_pkg::ST_COMP;
      end
      sha_pkg::ST_COMP: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) state_next = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        // fold rounds into the hash, then resume where the block left off
        cmd.final_add = 1'b1;
        state_next = ret;
      end
      sha_pkg::ST_OUT: begin
        if (!ov || out_ready) begin
          if (ol) begin
            ov_next = 1'b0;
            ol_next = 1'b0;
            cmd.finish = 1'b1;
            state_next = sha_pkg::ST_IDLE;
          end else begin
            cmd.out_load = 1'b1;
            ov_next = 1'b1;
            ol_next = (stat.out_idx == 3'd7);
          end
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov;
  assign out_last  = ol;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    ov |-> state == sha_pkg::ST_OUT)
    else $error("output valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ov)
    else $error("input ready while digest pending");
  a_last_pulse: assert property (@(posedge clk) disable iff (rst)
    (ov && ol && out_ready) |=> !ov)
    else $error("output valid after last word");

endmodule

// ===== hw/rtl/sha256_hash.sv =====
// SHA-256 hash engine top level.
// Depends on sha_pkg, sha_ctrl, sha_dp.
//
// Input channel (in_valid/in_ready): data_word, byte_count, last. Every item but
// the last carries four bytes; the last carries 0..4 and ends the message.
// Output channel (out_valid/out_ready): eight digest words H0..H7, last_word on H7.
// A non-last word is taken directly unless it fills the 16-word window, which then
// starts the compression rounds and the hash fold, all run by the single shared
// round unit; input is held off until they are done.
// After the last item the block writes the padding and length words and runs one
// or two compressions, then presents one digest word per cycle
// while the receiver takes them; a stalled receiver holds the word in the
// output register and the block waits. After H7 is taken the hash returns to
// the initial values and input is accepted again.
// Reset (rst, synchronous) restores the initial hash and clears the length.
module sha256_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        last_word
);

  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .byte_count, .last,
    .out_valid, .out_ready, .out_last(last_word), .cmd, .stat
  );

  sha_dp u_dp (
    .clk, .rst, .cmd, .stat, .data_word, .byte_count, .last,
    .out_word(digest_word)
  );

endmodule
